[src/smcm_pkg.sv]
// ----------------------------------------------------------------------------
// smcm_pkg
// Shared types and constants for the segment-masked complex matrix multiply.
// ----------------------------------------------------------------------------
`default_nettype none
package smcm_pkg;

  localparam int unsigned DEF_MAX_SITES    = 16;
  localparam int unsigned DEF_MAX_SEGMENTS = 16;

  localparam int unsigned IDX_W   = 4;   // index field width
  localparam int unsigned LAB_W   = 4;   // label field width
  localparam int unsigned SIZE_W  = 5;   // size register width
  localparam int unsigned PART_W  = 16;  // Q2.13 part
  localparam int unsigned PROD_W  = 33;  // one complex product term
  localparam int unsigned ACC_W   = 40;  // Q13.26 full sum

  // operation codes
  localparam logic [1:0] OP_LABEL   = 2'd0;
  localparam logic [1:0] OP_ELEM    = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  // register indexes
  localparam logic [1:0] REG_SIZE  = 2'd0;
  localparam logic [1:0] REG_ROW   = 2'd1;
  localparam logic [1:0] REG_INNER = 2'd2;
  localparam logic [1:0] REG_COL   = 2'd3;

  // word handed from cell to cell along the inner index
  typedef struct packed {
    logic                     vld;
    logic                     use_k;   // inner label matches and row is enabled
    logic signed [PART_W-1:0] ar;
    logic signed [PART_W-1:0] ai;
  } smcm_tok_t;

endpackage
`default_nettype wire

[src/smcm_cell.sv]
// ----------------------------------------------------------------------------
// smcm_cell
// One column MAC cell: multiplies the passing A element with its own B
// element and accumulates, then hands the A word to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none
module smcm_cell
  import smcm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     clr,      // start of a row
  input  wire smcm_tok_t                tok_in,
  input  wire logic signed [PART_W-1:0] br,
  input  wire logic signed [PART_W-1:0] bi,
  output smcm_tok_t                     tok_out,
  output logic signed [ACC_W-1:0]       acc_re,
  output logic signed [ACC_W-1:0]       acc_im
);

  logic signed [2*PART_W-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [PROD_W-1:0]   t_re, t_im;
  logic                       t_vld;

  // product stage
  always_ff @(posedge clk) begin
    p_rr  <= tok_in.ar * br;
    p_ii  <= tok_in.ai * bi;
    p_ri  <= tok_in.ar * bi;
    p_ir  <= tok_in.ai * br;
    t_vld <= tok_in.vld && tok_in.use_k;
  end

  assign t_re = PROD_W'(p_rr) - PROD_W'(p_ii);
  assign t_im = PROD_W'(p_ri) + PROD_W'(p_ir);

  // accumulate stage
  always_ff @(posedge clk) begin
    if (clr) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (t_vld) begin
      acc_re <= acc_re + ACC_W'(t_re);
      acc_im <= acc_im + ACC_W'(t_im);
    end
  end

  // pass A along the row of cells
  always_ff @(posedge clk) begin
    tok_out <= tok_in;
  end

endmodule
`default_nettype wire

[src/segment_masked_complex_matmul.sv]
// ----------------------------------------------------------------------------
// segment_masked_complex_matmul
// Complex C = A*B restricted to segment-labeled rows, columns and inner sums.
// ----------------------------------------------------------------------------
// A compute word streams A[row][k] for k = 0..N-1 through a chain of MAX_SITES
// column cells, one k per cycle; cell j holds B[k][j] read from its own bank.
// A row fills and drains the chain (MAX_SITES capped at 16), then emits the N
// sums, one per cycle while the output is not stalled, from an output register.
// Items are handled one at a time.
`default_nettype none
module segment_masked_complex_matmul
  import smcm_pkg::*;
#(
  parameter int unsigned MAX_SITES    = DEF_MAX_SITES
)(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [SIZE_W-1:0]        cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               operation,
  input  wire logic [IDX_W-1:0]         row,
  input  wire logic [IDX_W-1:0]         col,
  input  wire logic [LAB_W-1:0]         site_label,
  input  wire logic signed [PART_W-1:0] a_real,
  input  wire logic signed [PART_W-1:0] a_imag,
  input  wire logic signed [PART_W-1:0] b_real,
  input  wire logic signed [PART_W-1:0] b_imag,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [IDX_W-1:0]              out_col,
  output logic signed [ACC_W-1:0]       c_real,
  output logic signed [ACC_W-1:0]       c_imag,
  output logic                          last
);

  localparam int unsigned NS    = (MAX_SITES < 16) ? MAX_SITES : 16;
  localparam int unsigned NW    = $clog2(NS);
  localparam int unsigned NSW   = $clog2(NS + 1);
  localparam int unsigned DRAIN = NS + 3;
  localparam int unsigned DW    = $clog2(DRAIN + 1);

  typedef enum logic [1:0] {S_IDLE, S_FEED, S_DRAIN, S_EMIT} state_t;

  state_t            state;
  logic [SIZE_W-1:0] size_reg;
  logic [LAB_W-1:0]  row_seg, inner_seg, col_seg;
  logic [LAB_W-1:0]  labels [NS];
  logic [NW-1:0]     cur_row;
  logic              row_ok;
  logic [NSW-1:0]    n_cur;
  logic [NSW-1:0]    kcnt;
  logic [DW-1:0]     dcnt;
  logic [NSW-1:0]    ecnt;
  logic [2*PART_W-1:0] a_mem [2**(2*NW)];
  logic [2*PART_W-1:0] a_rd;
  logic [2*PART_W-1:0] b_mem [NS][NS];
  logic [2*PART_W-1:0] b_rd  [NS];
  logic              rd_vld, rd_use;
  logic              clr;
  smcm_tok_t         tok [NS+1];
  logic signed [ACC_W-1:0] acc_re [NS];
  logic signed [ACC_W-1:0] acc_im [NS];
  logic [NSW-1:0]    n_eff;
  logic              in_acc, out_free;
  logic              row_in, col_in;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign row_in    = (32'(row) < NS);
  assign col_in    = (32'(col) < NS);

  // clamp N
  always_comb begin
    if (size_reg == '0)              n_eff = NSW'(1);
    else if (32'(size_reg) > NS)     n_eff = NSW'(NS);
    else                             n_eff = NSW'(size_reg);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg  <= SIZE_W'(16);
      row_seg   <= '0;
      inner_seg <= '0;
      col_seg   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIZE:  size_reg  <= cfg_data;
        REG_ROW:   row_seg   <= cfg_data[LAB_W-1:0];
        REG_INNER: inner_seg <= cfg_data[LAB_W-1:0];
        REG_COL:   col_seg   <= cfg_data[LAB_W-1:0];
        default: ;
      endcase
    end
  end

  // label store: small register file, read at k, at the row and at the emitted column
  always_ff @(posedge clk) begin
    if (in_acc && operation == OP_LABEL && row_in)
      labels[row[NW-1:0]] <= site_label;
  end

  // A store: one read port, indexed {row, k}
  always_ff @(posedge clk) begin
    if (in_acc && operation == OP_ELEM && row_in && col_in)
      a_mem[{row[NW-1:0], col[NW-1:0]}] <= {a_real, a_imag};
    a_rd <= a_mem[{cur_row, kcnt[NW-1:0]}];
  end

  // B store: one bank per column, read at k
  for (genvar j = 0; j < NS; j++) begin : g_bbank
    always_ff @(posedge clk) begin
      if (in_acc && operation == OP_ELEM && row_in && col_in && 32'(col) == j)
        b_mem[j][row[NW-1:0]] <= {b_real, b_imag};
      b_rd[j] <= b_mem[j][kcnt[NW-1:0]];
    end
  end

  // read qualifiers, aligned with the registered reads
  always_ff @(posedge clk) begin
    rd_vld <= (state == S_FEED);
    rd_use <= (labels[kcnt[NW-1:0]] == inner_seg) && row_ok;
  end

  assign tok[0].vld   = rd_vld;
  assign tok[0].use_k = rd_use;
  assign tok[0].ar    = a_rd[2*PART_W-1:PART_W];
  assign tok[0].ai    = a_rd[PART_W-1:0];

  // B for cell j must match k of the token arriving there: delay per cell
  for (genvar j = 0; j < NS; j++) begin : g_cell
    logic [2*PART_W-1:0] b_al;
    if (j == 0) begin : g_b0
      assign b_al = b_rd[j];
    end else begin : g_bd
      logic [2*PART_W-1:0] bd [j];
      always_ff @(posedge clk) begin
        bd[0] <= b_rd[j];
        for (int d = 1; d < j; d++) bd[d] <= bd[d-1];
      end
      assign b_al = bd[j-1];
    end
    smcm_cell u_cell (
      .clk    (clk),
      .clr    (clr),
      .tok_in (tok[j]),
      .br     (b_al[2*PART_W-1:PART_W]),
      .bi     (b_al[PART_W-1:0]),
      .tok_out(tok[j+1]),
      .acc_re (acc_re[j]),
      .acc_im (acc_im[j])
    );
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      clr       <= 1'b0;
      kcnt      <= '0;
      dcnt      <= '0;
      ecnt      <= '0;
    end else begin
      clr <= 1'b0;
      case (state)
        S_IDLE: begin
          if (out_free) out_valid <= 1'b0;
          if (in_acc && operation == OP_COMPUTE) begin
            cur_row <= row[NW-1:0];
            row_ok  <= (NSW'(row) < n_eff) && (32'(row) < NS);
            n_cur   <= n_eff;
            kcnt    <= '0;
            clr     <= 1'b1;
            state   <= S_FEED;
          end
        end
        S_FEED: begin
          if (out_free) out_valid <= 1'b0;
          row_ok <= row_ok && (labels[cur_row] == row_seg);
          if (kcnt + NSW'(1) == n_cur) begin
            dcnt  <= '0;
            state <= S_DRAIN;
          end
          kcnt <= kcnt + NSW'(1);
        end
        S_DRAIN: begin
          if (out_free) out_valid <= 1'b0;
          dcnt <= dcnt + DW'(1);
          if (dcnt == DW'(DRAIN)) begin
            ecnt  <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_col   <= IDX_W'(ecnt);
            if (row_ok && labels[ecnt[NW-1:0]] == col_seg) begin
              c_real <= acc_re[ecnt[NW-1:0]];
              c_imag <= acc_im[ecnt[NW-1:0]];
            end else begin
              c_real <= '0;
              c_imag <= '0;
            end
            last <= (ecnt + NSW'(1) == n_cur);
            ecnt <= ecnt + NSW'(1);
            if (ecnt + NSW'(1) == n_cur) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // no input taken while a row is in flight
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  // a stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_col) && $stable(c_real)
      && $stable(c_imag) && $stable(last)))
    else $error("stalled word changed");
  // emit count never passes N
  a_ecnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (ecnt < n_cur)) else $error("emit overrun");

endmodule
`default_nettype wire
